// File: rtl/keyed_balance_table_macros.svh
// Assertion shorthands used by the checker file.
`ifndef KEYED_BALANCE_TABLE_MACROS_SVH
`define KEYED_BALANCE_TABLE_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define KBT_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is held.
`define KBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/kbt_pkg.sv
package kbt_pkg;

  localparam int MAX_ENTRIES_DEF = 64;
  localparam int KEY_W = 32;
  localparam int BAL_W = 32;
  localparam int CMD_W = 2;

  localparam logic [CMD_W-1:0] CMD_GET   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SPEND = 2'd2;

  typedef struct packed {
    logic [CMD_W-1:0] command;
    logic [KEY_W-1:0] item_key;
    logic [BAL_W-1:0] value_amount;
  } in_beat_t;

  typedef struct packed {
    logic             ok;
    logic [BAL_W-1:0] balance;
    logic             found;
  } out_beat_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic search;
    logic commit;
  } kbt_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic search_done;
    logic slot_free;
  } kbt_sts_t;

endpackage

// File: rtl/kbt_datapath.sv
module kbt_datapath #(
  parameter int MAX_ENTRIES = kbt_pkg::MAX_ENTRIES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  kbt_pkg::in_beat_t in_data,
  input  kbt_pkg::kbt_cmd_t cmd,
  output kbt_pkg::kbt_sts_t sts,
  output logic              out_valid,
  input  logic              out_stall,
  output kbt_pkg::out_beat_t out_data
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);
  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int KW = kbt_pkg::KEY_W;
  localparam int BW = kbt_pkg::BAL_W;
  localparam int DW = KW + BW;

  // each word holds {key, balance}
  logic [DW-1:0] mem [MAX_ENTRIES];

  logic [kbt_pkg::CMD_W-1:0] cmd_r, cmd_nxt;
  logic [KW-1:0]  key_r, key_nxt;
  logic [BW-1:0]  val_r, val_nxt;
  logic [CW-1:0]  count_r, count_nxt;
  logic [CW-1:0]  scan_r, scan_nxt;
  logic           cmp_vld_r, cmp_vld_nxt;
  logic [AW-1:0]  cmp_idx_r, cmp_idx_nxt;
  logic [DW-1:0]  rd_q_r;
  logic           found_r, found_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [BW-1:0]  cur_r, cur_nxt;
  logic           out_valid_r, out_valid_nxt;
  kbt_pkg::out_beat_t out_data_r, out_data_nxt;

  logic          issue;
  logic          hit;
  logic          room;
  logic          do_wr;
  logic          do_app;
  logic [BW-1:0] new_bal;
  logic [BW-1:0] diff;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  kbt_pkg::out_beat_t res;

  assign issue = cmd.search && (scan_r < count_r);
  assign hit   = cmp_vld_r && (rd_q_r[DW-1:BW] == key_r);
  assign room  = count_r < CW'(MAX_ENTRIES);
  assign diff  = cur_r - val_r;

  assign sts.search_done = hit || (!(scan_r < count_r) && !cmp_vld_r);
  assign sts.slot_free   = !out_valid_r || !out_stall;

  // outcome of the command once the search has settled
  always_comb begin
    res.ok      = 1'b0;
    res.balance = '0;
    res.found   = found_r;
    do_wr       = 1'b0;
    do_app      = 1'b0;
    new_bal     = val_r;
    if (key_r == '0) begin
      res.found = 1'b0;
    end else begin
      unique case (cmd_r)
        kbt_pkg::CMD_GET: begin
          res.ok      = 1'b1;
          res.balance = cur_r;
        end
        kbt_pkg::CMD_SET: begin
          if (found_r || room) begin
            do_wr       = 1'b1;
            do_app      = !found_r;
            res.ok      = 1'b1;
            res.balance = val_r;
          end
        end
        kbt_pkg::CMD_SPEND: begin
          res.balance = cur_r;
          new_bal     = diff;
          if ((cur_r >= val_r) && (found_r || room)) begin
            do_wr       = 1'b1;
            do_app      = !found_r;
            res.ok      = 1'b1;
            res.balance = diff;
          end
        end
        default: begin
          res.balance = cur_r;
        end
      endcase
    end
  end

  assign wr_en   = cmd.commit && do_wr;
  assign wr_addr = found_r ? idx_r : count_r[AW-1:0];

  always_comb begin
    cmd_nxt       = cmd_r;
    key_nxt       = key_r;
    val_nxt       = val_r;
    count_nxt     = count_r;
    scan_nxt      = scan_r;
    cmp_vld_nxt   = cmp_vld_r;
    cmp_idx_nxt   = cmp_idx_r;
    found_nxt     = found_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (cmd.load) begin
      cmd_nxt     = in_data.command;
      key_nxt     = in_data.item_key;
      val_nxt     = in_data.value_amount;
      scan_nxt    = '0;
      cmp_vld_nxt = 1'b0;
      found_nxt   = 1'b0;
      cur_nxt     = '0;
    end

    if (cmd.search) begin
      // one read issued per cycle, compared the cycle after
      cmp_vld_nxt = issue;
      cmp_idx_nxt = scan_r[AW-1:0];
      if (issue) begin
        scan_nxt = scan_r + CW'(1);
      end
      if (hit) begin
        found_nxt = 1'b1;
        idx_nxt   = cmp_idx_r;
        cur_nxt   = rd_q_r[BW-1:0];
      end
    end

    if (cmd.commit && do_app) begin
      count_nxt = count_r + CW'(1);
    end

    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r      <= cmd_nxt;
    key_r      <= key_nxt;
    val_r      <= val_nxt;
    scan_r     <= scan_nxt;
    cmp_idx_r  <= cmp_idx_nxt;
    found_r    <= found_nxt;
    idx_r      <= idx_nxt;
    cur_r      <= cur_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      rd_q_r <= mem[scan_r[AW-1:0]];
    end
    if (wr_en) begin
      mem[wr_addr] <= {key_r, new_bal};
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: rtl/kbt_ctrl.sv
module kbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  kbt_pkg::kbt_sts_t sts,
  output kbt_pkg::kbt_cmd_t cmd
);

  typedef enum logic [2:0] {
    ST_IDLE   = 3'b001,
    ST_SEARCH = 3'b010,
    ST_DECIDE = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // hold off the sender while reset is applied or a command is in progress
  assign in_stall   = !rst_n || (state_r != ST_IDLE);
  assign cmd.load   = in_valid && !in_stall;
  assign cmd.search = (state_r == ST_SEARCH);
  assign cmd.commit = (state_r == ST_DECIDE) && sts.slot_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (sts.search_done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        // hold until the result register can take the beat
        if (sts.slot_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: rtl/keyed_balance_table.sv
// channel   dir  handshake            payload
// in_       in   in_valid/in_stall    kbt_pkg::in_beat_t  (command, key, amount)
// out_      out  out_valid/out_stall  kbt_pkg::out_beat_t (ok, balance, found)
//
// One entry is read per cycle through a single read port; a command commits
// once its key matches an entry or the scan has passed every entry, and the
// next beat can be taken in the cycle after the commit.
// Synchronous active-low reset empties the table; the input stalls during reset.
// A stalled result sits in the output register; the next command is taken
// and searched meanwhile, and only its commit waits for the register.
module keyed_balance_table #(
  parameter int MAX_ENTRIES = kbt_pkg::MAX_ENTRIES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  kbt_pkg::in_beat_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output kbt_pkg::out_beat_t out_data
);

  kbt_pkg::kbt_cmd_t cmd;
  kbt_pkg::kbt_sts_t sts;

  kbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  kbt_datapath #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// File: rtl/kbt_checker.sv
`include "keyed_balance_table_macros.svh"

module kbt_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input kbt_pkg::in_beat_t  in_data,
  input logic               out_valid,
  input logic               out_stall,
  input kbt_pkg::out_beat_t out_data
);

  logic in_fire;
  logic in_wait;
  logic out_wait;
  logic out_reject;

  assign in_fire    = in_valid && !in_stall;
  assign in_wait    = in_valid && in_stall;
  assign out_wait   = out_valid && out_stall;
  assign out_reject = out_valid && !out_data.ok && !out_data.found;

  `KBT_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_fire, in_stall, "no busy after accept")
  `KBT_ASSERT_NEXT(a_in_hold, clk, rst_n, in_wait, $stable(in_data), "stalled input changed")
  `KBT_ASSERT_NOW(a_rej_zero, clk, rst_n, out_reject, out_data.balance == '0, "nonzero reject")
  `KBT_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_wait, out_valid, "stalled result dropped")
  `KBT_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_wait, $stable(out_data), "result changed")

endmodule

bind keyed_balance_table kbt_checker u_kbt_checker (.*);

// File: test/tb_keyed_balance_table.sv
module tb_keyed_balance_table;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = kbt_pkg::MAX_ENTRIES_DEF;
  localparam int KW = kbt_pkg::KEY_W;
  localparam int BW = kbt_pkg::BAL_W;
  localparam logic [kbt_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int POOL_SIZE = 24;
  localparam int HOLD_LEN = 300;
  localparam int SETTLE_CYCLES = TABLE_DEPTH + 40;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  kbt_pkg::in_beat_t  in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  kbt_pkg::out_beat_t out_data;

  keyed_balance_table #(
    .MAX_ENTRIES(TABLE_DEPTH)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the table contents, updated at each accepted command.
  logic [KW-1:0] tbl_keys [TABLE_DEPTH];
  logic [BW-1:0] tbl_bals [TABLE_DEPTH];
  int            tbl_count = 0;

  kbt_pkg::out_beat_t replies_due[$];
  logic [KW-1:0]      key_pool [POOL_SIZE];
  int                 err_count = 0;
  bit                 idle_on = 1'b1;
  bit                 hold_req = 1'b0;

  function automatic int ledger_find(logic [KW-1:0] key);
    for (int i = 0; i < tbl_count; i++) begin
      if (tbl_keys[i] == key) return i;
    end
    return -1;
  endfunction

  function automatic bit ledger_store(int idx, logic [KW-1:0] key, logic [BW-1:0] val);
    if (idx >= 0) begin
      tbl_bals[idx] = val;
      return 1'b1;
    end
    if (tbl_count >= TABLE_DEPTH) return 1'b0;
    tbl_keys[tbl_count] = key;
    tbl_bals[tbl_count] = val;
    tbl_count++;
    return 1'b1;
  endfunction

  function automatic kbt_pkg::out_beat_t ledger_apply(kbt_pkg::in_beat_t b);
    kbt_pkg::out_beat_t r;
    int                 idx;
    logic [BW-1:0]      cur;
    r = '0;
    if (b.item_key == '0) return r;
    idx = ledger_find(b.item_key);
    r.found = (idx >= 0);
    cur = (idx >= 0) ? tbl_bals[idx] : '0;
    case (b.command)
      kbt_pkg::CMD_GET: begin
        r.ok = 1'b1;
        r.balance = cur;
      end
      kbt_pkg::CMD_SET: begin
        if (ledger_store(idx, b.item_key, b.value_amount)) begin
          r.ok = 1'b1;
          r.balance = b.value_amount;
        end
      end
      kbt_pkg::CMD_SPEND: begin
        r.balance = cur;
        if (cur >= b.value_amount) begin
          if (ledger_store(idx, b.item_key, cur - b.value_amount)) begin
            r.ok = 1'b1;
            r.balance = cur - b.value_amount;
          end
        end
      end
      default: r.balance = cur;
    endcase
    return r;
  endfunction

  function automatic kbt_pkg::in_beat_t make_beat(logic [kbt_pkg::CMD_W-1:0] cmd,
                                                  logic [KW-1:0] key, logic [BW-1:0] val);
    kbt_pkg::in_beat_t b;
    b.command = cmd;
    b.item_key = key;
    b.value_amount = val;
    return b;
  endfunction

  function automatic logic [KW-1:0] fresh_key();
    logic [KW-1:0] k;
    do k = $urandom; while (k == '0);
    return k;
  endfunction

  // Mostly known keys; amounts often near the current balance so spends go both ways.
  function automatic kbt_pkg::in_beat_t rand_beat(int fresh_pct);
    kbt_pkg::in_beat_t b;
    int unsigned       r;
    int                idx;
    logic [BW-1:0]     cur;
    r = $urandom_range(0, 99);
    if (r < 4) b.item_key = '0;
    else if (r < 4 + fresh_pct) b.item_key = fresh_key();
    else b.item_key = key_pool[$urandom_range(0, POOL_SIZE-1)];
    r = $urandom_range(0, 99);
    if (r < 28) b.command = kbt_pkg::CMD_GET;
    else if (r < 58) b.command = kbt_pkg::CMD_SET;
    else if (r < 94) b.command = kbt_pkg::CMD_SPEND;
    else b.command = CMD_UNUSED;
    idx = ledger_find(b.item_key);
    cur = (idx >= 0) ? tbl_bals[idx] : '0;
    case ($urandom_range(0, 6))
      0: b.value_amount = '0;
      1: b.value_amount = cur;
      2: b.value_amount = cur + 1'b1;
      3: b.value_amount = $urandom_range(0, cur);
      4: b.value_amount = $urandom;
      5: b.value_amount = $urandom_range(0, 255);
      default: b.value_amount = '1;
    endcase
    return b;
  endfunction

  task automatic send_beat(kbt_pkg::in_beat_t b);
    int gap;
    gap = idle_on ? $urandom_range(0, 15) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_data <= b;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    replies_due.push_back(ledger_apply(b));
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
  endtask

  task automatic report_mismatch(string what, logic [BW-1:0] got, logic [BW-1:0] want);
    $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
    err_count++;
  endtask

  always @(posedge clk) begin
    kbt_pkg::out_beat_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (replies_due.size() == 0) begin
        report_mismatch("unexpected result beat, balance", out_data.balance, '0);
      end else begin
        want = replies_due.pop_front();
        if (out_data.ok !== want.ok)
          report_mismatch("ok", BW'(out_data.ok), BW'(want.ok));
        if (out_data.balance !== want.balance)
          report_mismatch("balance", out_data.balance, want.balance);
        if (out_data.found !== want.found)
          report_mismatch("found", BW'(out_data.found), BW'(want.found));
      end
    end
  end

  // Result side: random stall before each beat while idle_on is set, one long hold-off on request.
  initial begin
    int n;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        n = HOLD_LEN;
        hold_req = 1'b0;
      end else begin
        n = idle_on ? $urandom_range(0, 15) : 0;
      end
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic test_directed();
    logic [KW-1:0] ka;
    logic [KW-1:0] kb;
    logic [KW-1:0] kc;
    ka = 32'h8000_0001;
    kb = 32'h0000_7FFE;
    kc = 32'h5A5A_A5A5;
    // key zero is rejected for every command
    send_beat(make_beat(kbt_pkg::CMD_GET, '0, '0));
    send_beat(make_beat(kbt_pkg::CMD_SET, '0, 32'd5));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, '0, '0));
    send_beat(make_beat(CMD_UNUSED, '0, '1));
    send_beat(make_beat(kbt_pkg::CMD_GET, ka, '1));
    send_beat(make_beat(CMD_UNUSED, ka, '0));
    send_beat(make_beat(kbt_pkg::CMD_SET, ka, '1));
    send_beat(make_beat(kbt_pkg::CMD_GET, ka, '0));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, ka, '1));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, ka, 32'd1));
    send_beat(make_beat(kbt_pkg::CMD_SET, ka, 32'h1234_5678));
    send_beat(make_beat(CMD_UNUSED, ka, 32'd7));
    // zero spend on an absent key appends a zero balance
    send_beat(make_beat(kbt_pkg::CMD_SPEND, kb, '0));
    send_beat(make_beat(kbt_pkg::CMD_GET, kb, '0));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, kc, 32'd5));
    send_beat(make_beat(kbt_pkg::CMD_GET, kc, '0));
    send_beat(make_beat(kbt_pkg::CMD_SET, '1, '0));
    send_beat(make_beat(kbt_pkg::CMD_SET, 32'd1, 32'hAAAA_AAAA));
    send_beat(make_beat(kbt_pkg::CMD_SET, '1, 32'h5555_5555));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, 32'd1, 32'h2AAA_AAAA));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, '1, 32'h5555_5556));
    send_beat(make_beat(kbt_pkg::CMD_GET, '1, '0));
  endtask

  task automatic test_random_mix(int count);
    key_pool[0] = 32'd1;
    key_pool[1] = '1;
    key_pool[2] = 32'h8000_0001;
    for (int i = 3; i < POOL_SIZE; i++) key_pool[i] = fresh_key();
    for (int i = 0; i < count; i++) begin
      idle_on = ((i % 60) >= 15);
      send_beat(rand_beat(3));
    end
    idle_on = 1'b1;
  endtask

  task automatic test_back_pressure(int count);
    idle_on = 1'b0;
    hold_req = 1'b1;
    for (int i = 0; i < count; i++) send_beat(rand_beat(3));
    // pause the sender until every reply is back
    wait_drained();
    idle_on = 1'b1;
  endtask

  task automatic test_fill_table();
    logic [KW-1:0] k;
    while (tbl_count < TABLE_DEPTH)
      send_beat(make_beat(kbt_pkg::CMD_SET, fresh_key(), $urandom));
    k = fresh_key();
    send_beat(make_beat(kbt_pkg::CMD_SET, k, 32'd9));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, k, '0));
    send_beat(make_beat(kbt_pkg::CMD_GET, k, '0));
    // last entry takes the longest search of any stored key
    send_beat(make_beat(kbt_pkg::CMD_SET, tbl_keys[TABLE_DEPTH-1], 32'd100));
    send_beat(make_beat(kbt_pkg::CMD_SPEND, tbl_keys[TABLE_DEPTH-1], 32'd100));
    send_beat(make_beat(kbt_pkg::CMD_GET, tbl_keys[TABLE_DEPTH-1], '0));
  endtask

  task automatic test_random_full(int count);
    for (int i = 0; i < count; i++) begin
      idle_on = ((i % 50) >= 12);
      send_beat(rand_beat(10));
    end
    idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_random_mix(220);
    test_back_pressure(40);
    test_fill_table();
    test_random_full(200);
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/kbt_pkg.sv
rtl/kbt_datapath.sv
rtl/kbt_ctrl.sv
rtl/keyed_balance_table.sv
rtl/kbt_checker.sv
test/tb_keyed_balance_table.sv
